/* design/mtbg_pkg.sv */
package mtbg_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_WORDS);
   localparam int POS_W        = $clog2(STATE_WORDS + 1);

   localparam logic [31:0] KNUTH_MULT   = 32'd1812433253;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
   localparam logic [31:0] HIGH_BIT     = 32'h80000000;
   localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc60000;
   localparam logic [31:0] SEED_DEFAULT = 32'd5489;

   localparam logic [1:0] CMD_RESEED  = 2'd0;
   localparam logic [1:0] CMD_RAW     = 2'd1;
   localparam logic [1:0] CMD_BOUNDED = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic        wr_en;
      addr_type    wr_addr;
      logic [31:0] wr_data;
      addr_type    rd_addr_a;
      addr_type    rd_addr_b;
   } mem_ctrl_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [63:0] cover_mask(input logic [63:0] lim);
      logic [63:0] m;
      m = lim;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      m = m | (m >> 32);
      return m;
   endfunction

endpackage

/* design/mtbg_store.sv */
module mtbg_store (
   input  logic                 clock,
   input  mtbg_pkg::mem_ctrl_type mem_ctrl,
   output logic [31:0]          rd_data_a,
   output logic [31:0]          rd_data_b
);
   import mtbg_pkg::*;

   logic [31:0] words_ff [STATE_WORDS];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         words_ff[mem_ctrl.wr_addr] <= mem_ctrl.wr_data;
      end
      rd_a_ff <= words_ff[mem_ctrl.rd_addr_a];
      rd_b_ff <= words_ff[mem_ctrl.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* design/mt19937_bounded_generator.sv */
// a raw draw runs dispatch, word read and temper before the strobe; a full
// twist of the 624-word store runs each 624 words; reseed writes and advances
// each word in turn (one shared 32x32 multiplier); a bounded draw reads and
// tempers each word and repeats on rejection. one request at a time: busy stays
// high until the strobe, and the next request is taken the cycle after. the
// strobe lasts exactly one cycle. synchronous reset: seed 5489, store unseeded, idle.
module mt19937_bounded_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_range_max,
   output logic        rsp_valid,
   output logic [63:0] rsp_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import mtbg_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SEED_WR  = 4'd1;
   localparam logic [3:0] ST_SEED_ADD = 4'd2;
   localparam logic [3:0] ST_DISPATCH = 4'd3;
   localparam logic [3:0] ST_TW_RD0   = 4'd4;
   localparam logic [3:0] ST_TW_LD    = 4'd5;
   localparam logic [3:0] ST_TW_RD    = 4'd6;
   localparam logic [3:0] ST_TW_WR    = 4'd7;
   localparam logic [3:0] ST_WD_RD    = 4'd8;
   localparam logic [3:0] ST_WD_TEMP  = 4'd9;
   localparam logic [3:0] ST_DONE     = 4'd10;

   localparam addr_type   LAST_IDX  = addr_type'(STATE_WORDS - 1);
   localparam addr_type   FAR_UP    = addr_type'(TWIST_OFFSET);
   localparam addr_type   FAR_DOWN  = addr_type'(STATE_WORDS - TWIST_OFFSET);
   localparam logic [POS_W-1:0] POS_END = POS_W'(STATE_WORDS);

   logic [3:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             seeded_ff, seeded_in;
   logic [31:0]      seed_ff, seed_in;
   addr_type         cnt_ff, cnt_in;
   logic [31:0]      s_ff, s_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      cur_ff, cur_in;
   logic [31:0]      hi_ff, hi_in;
   logic             half_ff, half_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [63:0]      limit_ff, limit_in;
   logic [63:0]      mask_ff, mask_in;
   logic [63:0]      value_ff, value_in;

   mem_ctrl_type mem_ctrl;
   logic [31:0]  rd_data_a;
   logic [31:0]  rd_data_b;
   logic [31:0]  tw_y;
   logic [31:0]  tw_word;
   logic [31:0]  tmp_word;
   logic [63:0]  draw_v;
   addr_type     nxt_addr;
   addr_type     far_addr;

   mtbg_store u_store (
      .clock     (clock),
      .mem_ctrl  (mem_ctrl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign nxt_addr = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + addr_type'(1);
   assign far_addr = (cnt_ff < FAR_DOWN) ? cnt_ff + FAR_UP : cnt_ff - FAR_DOWN;
   assign tw_y     = (cur_ff & HIGH_BIT) | (rd_data_a & LOW_BITS);
   assign tw_word  = rd_data_b ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'd0);
   assign tmp_word = temper(rd_data_a);
   assign draw_v   = half_ff ? ({hi_ff, tmp_word} & mask_ff)
                             : ({32'd0, tmp_word} & mask_ff);

   always_comb begin
      mem_ctrl = '0;
      case (state_ff)
         ST_SEED_WR: begin
            mem_ctrl.wr_en   = 1'b1;
            mem_ctrl.wr_addr = cnt_ff;
            mem_ctrl.wr_data = s_ff;
         end
         ST_TW_RD0: begin
            mem_ctrl.rd_addr_a = '0;
         end
         ST_TW_RD: begin
            mem_ctrl.rd_addr_a = nxt_addr;
            mem_ctrl.rd_addr_b = far_addr;
         end
         ST_TW_WR: begin
            mem_ctrl.wr_en   = 1'b1;
            mem_ctrl.wr_addr = cnt_ff;
            mem_ctrl.wr_data = tw_word;
         end
         ST_WD_RD: begin
            mem_ctrl.rd_addr_a = pos_ff[ADDR_W-1:0];
         end
         default: begin
            mem_ctrl = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      seeded_in = seeded_ff;
      seed_in   = csr_wr_en ? csr_wr_data : seed_ff;
      cnt_in    = cnt_ff;
      s_in      = s_ff;
      prod_in   = prod_ff;
      cur_in    = cur_ff;
      hi_in     = hi_ff;
      half_in   = half_ff;
      cmd_in    = cmd_ff;
      limit_in  = limit_ff;
      mask_in   = mask_ff;
      value_in  = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               limit_in = req_range_max;
               mask_in  = cover_mask(req_range_max);
               half_in  = 1'b0;
               cnt_in   = '0;
               s_in     = seed_ff;
               value_in = '0;
               case (req_command)
                  CMD_NONE:   state_in = ST_DONE;
                  CMD_RESEED: state_in = ST_SEED_WR;
                  default:    state_in = seeded_ff ? ST_DISPATCH : ST_SEED_WR;
               endcase
            end
         end
         ST_SEED_WR: begin
            prod_in = KNUTH_MULT * (s_ff ^ (s_ff >> 30));
            if (cnt_ff == LAST_IDX) begin
               pos_in    = POS_END;
               seeded_in = 1'b1;
               state_in  = (cmd_ff == CMD_RESEED) ? ST_DONE : ST_DISPATCH;
            end else begin
               state_in = ST_SEED_ADD;
            end
         end
         ST_SEED_ADD: begin
            s_in     = prod_ff + 32'(cnt_ff) + 32'd1;
            cnt_in   = cnt_ff + addr_type'(1);
            state_in = ST_SEED_WR;
         end
         ST_DISPATCH: begin
            if (cmd_ff == CMD_BOUNDED && limit_ff == 64'd0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WD_RD;
            end
         end
         ST_TW_RD0: begin
            state_in = ST_TW_LD;
         end
         ST_TW_LD: begin
            cur_in   = rd_data_a;
            state_in = ST_TW_RD;
         end
         ST_TW_RD: begin
            state_in = ST_TW_WR;
         end
         ST_TW_WR: begin
            cur_in = rd_data_a;
            if (cnt_ff == LAST_IDX) begin
               pos_in   = '0;
               state_in = ST_WD_RD;
            end else begin
               cnt_in   = cnt_ff + addr_type'(1);
               state_in = ST_TW_RD;
            end
         end
         ST_WD_RD: begin
            if (pos_ff >= POS_END) begin
               cnt_in   = '0;
               state_in = ST_TW_RD0;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_WD_TEMP;
            end
         end
         ST_WD_TEMP: begin
            if (cmd_ff == CMD_RAW) begin
               value_in = {32'd0, tmp_word};
               state_in = ST_DONE;
            end else if (limit_ff[63:32] != 32'd0 && !half_ff) begin
               hi_in    = tmp_word;
               half_in  = 1'b1;
               state_in = ST_WD_RD;
            end else begin
               half_in = 1'b0;
               if (draw_v <= limit_ff) begin
                  value_in = draw_v;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WD_RD;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= POS_END;
         seeded_ff <= 1'b0;
         seed_ff   <= SEED_DEFAULT;
         cnt_ff    <= '0;
         half_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         seeded_ff <= seeded_in;
         seed_ff   <= seed_in;
         cnt_ff    <= cnt_in;
         half_ff   <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      prod_ff  <= prod_in;
      cur_ff   <= cur_in;
      hi_ff    <= hi_in;
      cmd_ff   <= cmd_in;
      limit_ff <= limit_in;
      mask_ff  <= mask_in;
      value_ff <= value_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_value = value_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_END)
      else $error("word position beyond store");

   a_raw_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cmd_ff == CMD_RAW |-> rsp_value[63:32] == 32'd0)
      else $error("raw result wider than one word");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cmd_ff == CMD_BOUNDED |-> rsp_value <= limit_ff)
      else $error("bounded result above range");
`endif

endmodule
